>>> hdl/mctc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mctc_pkg;

   // fixed field widths of the request and response words
   localparam int ADDR_W  = 32;
   localparam int WAYS    = 8;
   localparam int WAY_W   = 3;
   localparam int AGE_W   = 3;
   localparam int STATE_W = 3;
   localparam int BUS_W   = 3;

   localparam logic [AGE_W-1:0] AGE_MAX = 3'd7;

   // request opcodes
   localparam logic [1:0] OP_CPU_READ    = 2'd0;
   localparam logic [1:0] OP_CPU_WRITE   = 2'd1;
   localparam logic [1:0] OP_SNOOP_READ  = 2'd2;
   localparam logic [1:0] OP_SNOOP_WRITE = 2'd3;

   // coherence codes
   localparam logic [STATE_W-1:0] MOESI_I = 3'd0;
   localparam logic [STATE_W-1:0] MOESI_S = 3'd1;
   localparam logic [STATE_W-1:0] MOESI_E = 3'd2;
   localparam logic [STATE_W-1:0] MOESI_O = 3'd3;
   localparam logic [STATE_W-1:0] MOESI_M = 3'd4;

   // bus action codes
   localparam logic [BUS_W-1:0] BUS_NONE       = 3'd0;
   localparam logic [BUS_W-1:0] BUS_PROBE_READ = 3'd1;
   localparam logic [BUS_W-1:0] BUS_INVALIDATE = 3'd2;
   localparam logic [BUS_W-1:0] BUS_FILL       = 3'd3;
   localparam logic [BUS_W-1:0] BUS_FILL_INV   = 3'd4;

   // sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } mctc_state_type;

   // outcome of the way scan
   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] hit_way;
      logic [WAY_W-1:0] best_way;
      logic [AGE_W-1:0] best_age;
   } scan_result_type;

endpackage

`default_nettype wire

>>> hdl/mctc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mctc_req_if
   import mctc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [ADDR_W-1:0] address;
   logic              from_memory;

   modport source (output valid, output opcode, output address, output from_memory,
                   input ready);
   modport sink   (input valid, input opcode, input address, input from_memory,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/mctc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mctc_rsp_if
   import mctc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               hit;
   logic [WAY_W-1:0]   way;
   logic               victim_writeback;
   logic [BUS_W-1:0]   bus_action;
   logic [STATE_W-1:0] line_state;

   modport source (output valid, output hit, output way, output victim_writeback,
                   output bus_action, output line_state, input ready);
   modport sink   (input valid, input hit, input way, input victim_writeback,
                   input bus_action, input line_state, output ready);
endinterface

`default_nettype wire

>>> hdl/mctc_set_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mctc_set_ram #(
   parameter int ADDR_BITS = 7,
   parameter int DATA_W    = 208
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]    wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output      logic [DATA_W-1:0]    rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_BITS];
   logic [DATA_W-1:0] rd_data_ff;

   // one row per set, all ways side by side
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/mctc_way_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module mctc_way_scan
   import mctc_pkg::*;
#(
   parameter int TAG_W = 20
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 scan_en,
   input  wire logic [WAY_W-1:0]     scan_way,
   input  wire logic [TAG_W-1:0]     entry_tag,
   input  wire logic [STATE_W-1:0]   entry_state,
   input  wire logic [AGE_W-1:0]     entry_age,
   input  wire logic [TAG_W-1:0]     req_tag,
   output      scan_result_type      result
);

   logic             hit_ff, hit_in;
   logic [WAY_W-1:0] hit_way_ff, hit_way_in;
   logic [WAY_W-1:0] best_way_ff, best_way_in;
   logic [AGE_W-1:0] best_age_ff, best_age_in;
   logic             first;
   logic             match;

   assign first = (scan_way == '0);
   assign match = (entry_state != MOESI_I) && (entry_tag == req_tag);

   // first valid match and first greatest age, one way per cycle while scan_en is high
   always_comb begin
      hit_in      = hit_ff;
      hit_way_in  = hit_way_ff;
      best_way_in = best_way_ff;
      best_age_in = best_age_ff;
      if (scan_en) begin
         if (first) begin
            hit_in      = match;
            hit_way_in  = scan_way;
            best_way_in = scan_way;
            best_age_in = entry_age;
         end else begin
            if (!hit_ff && match) begin
               hit_in     = 1'b1;
               hit_way_in = scan_way;
            end
            if (entry_age > best_age_ff) begin
               best_way_in = scan_way;
               best_age_in = entry_age;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_way_ff  <= hit_way_in;
      best_way_ff <= best_way_in;
      best_age_ff <= best_age_in;
   end

   assign result.hit      = hit_ff;
   assign result.hit_way  = hit_way_ff;
   assign result.best_way = best_way_ff;
   assign result.best_age = best_age_ff;

endmodule

`default_nettype wire

>>> hdl/moesi_cache_tag_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// MOESI tag and state store of an 8-way set-associative cache with age-based
// replacement. After reset the block sweeps every set once to load the reset tags,
// states and ages, with req_chan.ready low. After that it takes one request word at
// a time and accepts no new one until the row is written back: the set row is read
// from memory, the eight ways go one per cycle through
// a single tag and age compare unit, and the updated row is written back while the
// response word is loaded into the output register. The response appears the cycle
// after the write and may wait there while the next request is already accepted; if
// it is still waiting when the next write cycle comes, that write cycle is held
// until the response word is taken.
module moesi_cache_tag_controller
   import mctc_pkg::*;
#(
   parameter int SET_BITS     = 7,
   parameter int OFFSET_BITS  = 5,
   parameter int ADDRESS_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   mctc_req_if.sink   req_chan,
   mctc_rsp_if.source rsp_chan
);

   localparam int TAG_W   = ADDR_W - SET_BITS - OFFSET_BITS;
   localparam int ENTRY_W = TAG_W + STATE_W + AGE_W;
   localparam int ROW_W   = WAYS * ENTRY_W;
   localparam logic [ADDR_W-1:0] AMASK = (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                         ((ADDR_W'(1) << ADDRESS_BITS) - ADDR_W'(1));

   mctc_state_type state_ff, state_in;

   logic [SET_BITS-1:0] clr_ff, clr_in;
   logic [WAY_W-1:0]    way_ff, way_in;
   logic [1:0]          op_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [SET_BITS-1:0] set_ff;
   logic                from_mem_ff;

   logic [ADDR_W-1:0]   masked_addr;
   logic                req_fire;
   logic                out_free;

   logic                ram_wr_en;
   logic [SET_BITS-1:0] ram_wr_addr;
   logic [ROW_W-1:0]    ram_wr_data;
   logic [ROW_W-1:0]    row;
   logic [ROW_W-1:0]    reset_row;
   logic [ROW_W-1:0]    new_row;

   logic [ENTRY_W-1:0]  scan_entry;
   logic                scan_en;
   scan_result_type     scan_res;

   logic                write_go;
   logic                clear_go;

   // row update signals
   logic [WAY_W-1:0]    sel_way;
   logic [ENTRY_W-1:0]  sel_entry;
   logic [STATE_W-1:0]  cur_state;
   logic [AGE_W-1:0]    sel_age;
   logic                is_cpu;
   logic                state_wr;
   logic                tag_wr;
   logic                age_refresh;
   logic [STATE_W-1:0]  new_state;
   logic                hit_o;
   logic [WAY_W-1:0]    way_o;
   logic                wb_o;
   logic [BUS_W-1:0]    bus_o;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [WAY_W-1:0]    rsp_way_ff;
   logic                rsp_wb_ff;
   logic [BUS_W-1:0]    rsp_bus_ff;
   logic [STATE_W-1:0]  rsp_state_ff;

   assign masked_addr = req_chan.address & AMASK;
   assign req_fire    = req_chan.valid && req_chan.ready;
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (way_ff == WAY_W'(WAYS - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready = 1'b0;
      scan_en        = 1'b0;
      write_go       = 1'b0;
      clear_go       = 1'b0;
      unique case (state_ff)
         ST_CLEAR: clear_go = 1'b1;
         ST_IDLE:  req_chan.ready = 1'b1;
         ST_SCAN:  scan_en = 1'b1;
         ST_WRITE: write_go = out_free;
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   // clear counter and way counter
   always_comb begin
      clr_in = clr_ff;
      if (clear_go) begin
         clr_in = clr_ff + SET_BITS'(1);
      end
      way_in = '0;
      if (scan_en) begin
         way_in = way_ff + WAY_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         way_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         way_ff       <= way_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // captured request word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff       <= req_chan.opcode;
         tag_ff      <= masked_addr[ADDR_W-1:SET_BITS+OFFSET_BITS];
         set_ff      <= masked_addr[OFFSET_BITS +: SET_BITS];
         from_mem_ff <= req_chan.from_memory;
      end
   end

   // reset contents of one set row
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         reset_row[i*ENTRY_W +: ENTRY_W] = {{TAG_W{1'b0}}, MOESI_I, AGE_W'(i)};
      end
   end

   assign ram_wr_en   = clear_go || write_go;
   assign ram_wr_addr = clear_go ? clr_ff : set_ff;
   assign ram_wr_data = clear_go ? reset_row : new_row;

   mctc_set_ram #(
      .ADDR_BITS (SET_BITS),
      .DATA_W    (ROW_W)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (masked_addr[OFFSET_BITS +: SET_BITS]),
      .rd_data (row)
   );

   // shared compare unit walks the ways
   assign scan_entry = row[int'(way_ff)*ENTRY_W +: ENTRY_W];

   mctc_way_scan #(
      .TAG_W (TAG_W)
   ) u_way_scan (
      .clock       (clock),
      .reset       (reset),
      .scan_en     (scan_en),
      .scan_way    (way_ff),
      .entry_tag   (scan_entry[ENTRY_W-1 -: TAG_W]),
      .entry_state (scan_entry[AGE_W +: STATE_W]),
      .entry_age   (scan_entry[AGE_W-1:0]),
      .req_tag     (tag_ff),
      .result      (scan_res)
   );

   // coherence decision for the selected way
   assign is_cpu    = !op_ff[1];
   assign sel_way   = scan_res.hit ? scan_res.hit_way : scan_res.best_way;
   assign sel_entry = row[int'(sel_way)*ENTRY_W +: ENTRY_W];
   assign cur_state = sel_entry[AGE_W +: STATE_W];
   assign sel_age   = sel_entry[AGE_W-1:0];

   always_comb begin
      new_state = MOESI_I;
      state_wr  = 1'b0;
      tag_wr    = 1'b0;
      hit_o     = scan_res.hit;
      way_o     = sel_way;
      wb_o      = 1'b0;
      bus_o     = BUS_NONE;
      unique case (op_ff)
         OP_SNOOP_READ: begin
            if (scan_res.hit) begin
               state_wr = 1'b1;
               if (cur_state == MOESI_E) begin
                  new_state = MOESI_S;
               end else if (cur_state == MOESI_M) begin
                  new_state = MOESI_O;
               end else begin
                  new_state = cur_state;
               end
            end else begin
               way_o = '0;
            end
         end
         OP_SNOOP_WRITE: begin
            if (scan_res.hit) begin
               state_wr  = 1'b1;
               new_state = MOESI_I;
            end else begin
               way_o = '0;
            end
         end
         OP_CPU_READ: begin
            if (scan_res.hit) begin
               new_state = cur_state;
               bus_o     = BUS_PROBE_READ;
            end else begin
               state_wr  = 1'b1;
               tag_wr    = 1'b1;
               new_state = from_mem_ff ? MOESI_E : MOESI_S;
               bus_o     = BUS_FILL;
               wb_o      = (scan_res.best_age == AGE_MAX) &&
                           ((cur_state == MOESI_M) || (cur_state == MOESI_O));
            end
         end
         OP_CPU_WRITE: begin
            state_wr  = 1'b1;
            new_state = MOESI_M;
            if (scan_res.hit) begin
               bus_o = BUS_INVALIDATE;
            end else begin
               tag_wr = 1'b1;
               bus_o  = BUS_FILL_INV;
               wb_o   = (scan_res.best_age == AGE_MAX) &&
                        ((cur_state == MOESI_M) || (cur_state == MOESI_O));
            end
         end
         default: begin
            new_state = MOESI_I;
         end
      endcase
   end

   assign age_refresh = is_cpu && (sel_age != '0);

   // rebuild the set row: selected entry plus, on a CPU access to a way of nonzero age, aging of all ways
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         logic [TAG_W-1:0]   t;
         logic [STATE_W-1:0] s;
         logic [AGE_W-1:0]   a;
         t = row[i*ENTRY_W + AGE_W + STATE_W +: TAG_W];
         s = row[i*ENTRY_W + AGE_W +: STATE_W];
         a = row[i*ENTRY_W +: AGE_W];
         if (WAY_W'(i) == sel_way) begin
            if (state_wr) begin
               s = new_state;
            end
            if (tag_wr) begin
               t = tag_ff;
            end
            if (age_refresh) begin
               a = '0;
            end
         end else if (age_refresh && (a != AGE_MAX)) begin
            a = a + AGE_W'(1);
         end
         new_row[i*ENTRY_W +: ENTRY_W] = {t, s, a};
      end
   end

   // response register
   assign rsp_valid_in = write_go || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (write_go) begin
         rsp_hit_ff   <= hit_o;
         rsp_way_ff   <= way_o;
         rsp_wb_ff    <= wb_o;
         rsp_bus_ff   <= bus_o;
         rsp_state_ff <= new_state;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.hit              = rsp_hit_ff;
   assign rsp_chan.way              = rsp_way_ff;
   assign rsp_chan.victim_writeback = rsp_wb_ff;
   assign rsp_chan.bus_action       = rsp_bus_ff;
   assign rsp_chan.line_state       = rsp_state_ff;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mctc_pkg::*;

   localparam int SET_BITS    = 7;
   localparam int OFFSET_BITS = 5;
   localparam int SETS        = 1 << SET_BITS;
   localparam int TAG_W       = ADDR_W - SET_BITS - OFFSET_BITS;
   localparam int RANDOM_WORDS = 1576;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [ADDR_W-1:0] address;
      logic              from_memory;
   } access_type;

   typedef struct packed {
      logic               hit;
      logic [WAY_W-1:0]   way;
      logic               victim_writeback;
      logic [BUS_W-1:0]   bus_action;
      logic [STATE_W-1:0] line_state;
   } outcome_type;

   typedef struct {
      access_type  acc;
      bit          typed_in;
      outcome_type want;
   } script_row_type;

   logic clock;
   logic reset;

   mctc_req_if req_bus ();
   mctc_rsp_if rsp_bus ();

   moesi_cache_tag_controller #(
      .SET_BITS     (SET_BITS),
      .OFFSET_BITS  (OFFSET_BITS),
      .ADDRESS_BITS (ADDR_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shadow copy of the tag, coherence and age arrays
   logic [TAG_W-1:0]   tag_shadow [SETS][WAYS];
   logic [STATE_W-1:0] coh_shadow [SETS][WAYS];
   logic [AGE_W-1:0]   age_shadow [SETS][WAYS];

   outcome_type    expected_outcomes [$];
   script_row_type directed_rows [$];

   logic [TAG_W-1:0] tag_pool [12];
   int               focus_set [4] = '{0, 1, 2, SETS - 1};

   bit quiet;
   int mismatches;
   int words_checked;
   int hits_seen;
   int writebacks_seen;
   int snoop_hits;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic report(input string msg);
      mismatches++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   function automatic int unsigned pick_wait();
      return quiet ? 0 : $urandom_range(0, 14);
   endfunction

   // age update: unless the touched way is already 0, it goes to 0 and others count up to the maximum
   function automatic void refresh_ages(input logic [SET_BITS-1:0] s, input int w);
      if (age_shadow[s][w] == '0) return;
      for (int i = 0; i < WAYS; i++) begin
         if (i == w) age_shadow[s][i] = '0;
         else if (age_shadow[s][i] < AGE_MAX) age_shadow[s][i] = age_shadow[s][i] + 1'b1;
      end
   endfunction

   // lookup, replacement and coherence update of one access
   function automatic outcome_type resolve_access(input access_type acc);
      logic [SET_BITS-1:0] set_idx;
      logic [TAG_W-1:0]    tag;
      logic [STATE_W-1:0]  cur;
      outcome_type         o;
      bit                  found;
      int                  way;
      int                  best;
      set_idx = acc.address[OFFSET_BITS +: SET_BITS];
      tag     = acc.address[ADDR_W-1 -: TAG_W];
      o       = '0;
      found   = 1'b0;
      way     = 0;
      // lowest matching valid way wins
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (coh_shadow[set_idx][i] != MOESI_I && tag_shadow[set_idx][i] == tag) begin
            found = 1'b1;
            way   = i;
         end
      end
      if (acc.opcode == OP_SNOOP_READ || acc.opcode == OP_SNOOP_WRITE) begin
         // snoops never touch ages; a miss reports all zero
         if (found) begin
            cur   = coh_shadow[set_idx][way];
            o.hit = 1'b1;
            o.way = way[WAY_W-1:0];
            if (acc.opcode == OP_SNOOP_WRITE) o.line_state = MOESI_I;
            else if (cur == MOESI_E) o.line_state = MOESI_S;
            else if (cur == MOESI_M) o.line_state = MOESI_O;
            else o.line_state = cur;
            coh_shadow[set_idx][way] = o.line_state;
         end
      end else if (found) begin
         o.hit = 1'b1;
         o.way = way[WAY_W-1:0];
         if (acc.opcode == OP_CPU_WRITE) begin
            coh_shadow[set_idx][way] = MOESI_M;
            o.bus_action = BUS_INVALIDATE;
         end else begin
            o.bus_action = BUS_PROBE_READ;
         end
         o.line_state = coh_shadow[set_idx][way];
         refresh_ages(set_idx, way);
      end else begin
         // victim is the first way of greatest age
         best = 0;
         for (int i = 1; i < WAYS; i++)
            if (age_shadow[set_idx][i] > age_shadow[set_idx][best]) best = i;
         cur   = coh_shadow[set_idx][best];
         o.way = best[WAY_W-1:0];
         if (age_shadow[set_idx][best] == AGE_MAX && (cur == MOESI_M || cur == MOESI_O))
            o.victim_writeback = 1'b1;
         if (acc.opcode == OP_CPU_WRITE) begin
            o.line_state = MOESI_M;
            o.bus_action = BUS_FILL_INV;
         end else begin
            o.line_state = acc.from_memory ? MOESI_E : MOESI_S;
            o.bus_action = BUS_FILL;
         end
         coh_shadow[set_idx][best] = o.line_state;
         tag_shadow[set_idx][best] = tag;
         refresh_ages(set_idx, best);
      end
      return o;
   endfunction

   task automatic add_row(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                          input logic fm, input bit typed_in, input outcome_type want);
      script_row_type r;
      r.acc      = '{op, addr, fm};
      r.typed_in = typed_in;
      r.want     = want;
      directed_rows.push_back(r);
   endtask

   // drive one request word and record what it should produce
   task automatic send_access(input access_type acc, input bit typed_in,
                              input outcome_type want);
      int unsigned gap;
      outcome_type predicted;
      gap = pick_wait();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= acc.opcode;
      req_bus.address     <= acc.address;
      req_bus.from_memory <= acc.from_memory;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = resolve_access(acc);
      expected_outcomes.push_back(typed_in ? want : predicted);
   endtask

   // compare one response word with the oldest pending one
   task automatic check_outcome(input outcome_type got);
      outcome_type want;
      if (expected_outcomes.size() == 0) begin
         report("response word with nothing pending");
         return;
      end
      want = expected_outcomes.pop_front();
      words_checked++;
      if (got.hit) hits_seen++;
      if (got.victim_writeback) writebacks_seen++;
      if (got.hit && got.bus_action == BUS_NONE) snoop_hits++;
      if (got.hit !== want.hit)
         report($sformatf("hit got %0b want %0b", got.hit, want.hit));
      if (got.way !== want.way)
         report($sformatf("way got %0d want %0d", got.way, want.way));
      if (got.victim_writeback !== want.victim_writeback)
         report($sformatf("victim_writeback got %0b want %0b",
                          got.victim_writeback, want.victim_writeback));
      if (got.bus_action !== want.bus_action)
         report($sformatf("bus_action got %0d want %0d", got.bus_action, want.bus_action));
      if (got.line_state !== want.line_state)
         report($sformatf("line_state got %0d want %0d", got.line_state, want.line_state));
   endtask

   // response side with random back-pressure
   initial begin
      int unsigned stall;
      forever begin
         stall = pick_wait();
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         check_outcome('{rsp_bus.hit, rsp_bus.way, rsp_bus.victim_writeback,
                         rsp_bus.bus_action, rsp_bus.line_state});
      end
   end

   // stimulus
   initial begin
      access_type       acc;
      logic [TAG_W-1:0] tag;
      int               s;
      int               pick;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= OP_CPU_READ;
      req_bus.address     <= '0;
      req_bus.from_memory <= 1'b0;
      quiet      = 1'b0;
      mismatches = 0;

      for (int i = 0; i < SETS; i++)
         for (int w = 0; w < WAYS; w++) begin
            tag_shadow[i][w] = '0;
            coh_shadow[i][w] = MOESI_I;
            age_shadow[i][w] = w[AGE_W-1:0];
         end

      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < 12; i++) tag_pool[i] = TAG_W'($urandom());

      // snoop misses on an empty cache
      add_row(OP_SNOOP_READ,  32'h0000_0000, 1'b0, 1, '{0, 0, 0, BUS_NONE, MOESI_I});
      add_row(OP_SNOOP_WRITE, 32'hFFFF_FFFF, 1'b1, 1, '{0, 0, 0, BUS_NONE, MOESI_I});
      // one line of set 0 walked through every coherence state
      add_row(OP_CPU_READ,    32'h0000_0000, 1'b1, 1, '{0, 7, 0, BUS_FILL, MOESI_E});
      add_row(OP_CPU_READ,    32'h0000_001F, 1'b0, 1, '{1, 7, 0, BUS_PROBE_READ, MOESI_E});
      add_row(OP_SNOOP_READ,  32'h0000_0000, 1'b1, 1, '{1, 7, 0, BUS_NONE, MOESI_S});
      add_row(OP_SNOOP_READ,  32'h0000_0000, 1'b0, 1, '{1, 7, 0, BUS_NONE, MOESI_S});
      add_row(OP_CPU_WRITE,   32'h0000_0000, 1'b0, 1, '{1, 7, 0, BUS_INVALIDATE, MOESI_M});
      add_row(OP_SNOOP_READ,  32'h0000_0000, 1'b0, 1, '{1, 7, 0, BUS_NONE, MOESI_O});
      add_row(OP_SNOOP_READ,  32'h0000_0000, 1'b0, 1, '{1, 7, 0, BUS_NONE, MOESI_O});
      add_row(OP_CPU_WRITE,   32'h0000_0000, 1'b1, 1, '{1, 7, 0, BUS_INVALIDATE, MOESI_M});
      add_row(OP_SNOOP_WRITE, 32'h0000_0000, 1'b0, 1, '{1, 7, 0, BUS_NONE, MOESI_I});
      // top set, all-ones tag, then a shared fill
      add_row(OP_CPU_WRITE,   32'hFFFF_FFFF, 1'b1, 1, '{0, 7, 0, BUS_FILL_INV, MOESI_M});
      add_row(OP_CPU_READ,    32'hFFFF_EFE0, 1'b0, 1, '{0, 6, 0, BUS_FILL, MOESI_S});
      // fill set 1 with dirty lines, then evict a modified and an owned victim
      for (int t = 1; t <= 9; t++)
         add_row(OP_CPU_WRITE, {t[TAG_W-1:0], 7'd1, 5'd0}, t[0], 0, '0);
      add_row(OP_SNOOP_READ, {20'd2, 7'd1, 5'd0}, 1'b0, 0, '0);
      add_row(OP_CPU_READ,   {20'd10, 7'd1, 5'd0}, 1'b1, 0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_access(directed_rows[i].acc, directed_rows[i].typed_in, directed_rows[i].want);

      // random part: mostly a few hot sets and a small tag pool, some wide-open noise
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         quiet = ((n % 250) >= 200);
         pick  = $urandom_range(0, 9);
         if (pick <= 3) acc.opcode = OP_CPU_READ;
         else if (pick <= 6) acc.opcode = OP_CPU_WRITE;
         else if (pick <= 8) acc.opcode = OP_SNOOP_READ;
         else acc.opcode = OP_SNOOP_WRITE;
         acc.from_memory = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 99) < 85) begin
            s   = focus_set[$urandom_range(0, 3)];
            tag = tag_pool[$urandom_range(0, 11)];
            acc.address = {tag, s[SET_BITS-1:0], 5'($urandom())};
         end else begin
            acc.address = $urandom();
         end
         send_access(acc, 0, '0);
      end
      req_bus.valid <= 1'b0;
      quiet = 1'b0;

      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("checked %0d response words: %0d hits, %0d snoop hits, %0d victim write-backs",
               words_checked, hits_seen, snoop_hits, writebacks_seen);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
